// ===== rtl/core/gbcd_pkg.sv =====
package gbcd_pkg;

    // default size of the character store
    localparam int DISPLAY_BYTES_DEF = 128;

    // item command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PEEK  = 2'd2;

    // bank-relative register offsets
    localparam logic [9:0] REL_PE_SET   = 10'h000;
    localparam logic [9:0] REL_PE_CLR   = 10'h004;
    localparam logic [9:0] REL_PE_RD    = 10'h008;
    localparam logic [9:0] REL_OE_SET   = 10'h010;
    localparam logic [9:0] REL_OE_CLR   = 10'h014;
    localparam logic [9:0] REL_OE_RD    = 10'h018;
    localparam logic [9:0] REL_OD_SET   = 10'h030;
    localparam logic [9:0] REL_OD_CLR   = 10'h034;
    localparam logic [9:0] REL_OD_RD    = 10'h038;
    localparam logic [9:0] REL_NOP      = 10'h070;
    localparam logic [9:0] REL_DISPLAY  = 10'h100;

    // display control bits in bank C; LED bits: yellow in bank B, green and red in bank C
    localparam logic [31:0] DISPLAY_GATE = 32'h0000_1C00;
    localparam int          CS_POS       = 12;
    localparam int          MODE_DATA    = 10;
    localparam int          MODE_HI      = 11;
    localparam int          YELLOW_POS   = 27;
    localparam int          GREEN_POS    = 1;
    localparam int          RED_POS      = 0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WIPE,
        ST_DONE,
        ST_OUT
    } gbcd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic capture;
    } gbcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_req;
        logic sweep_last;
    } gbcd_status_t;

endpackage

// ===== rtl/core/gbcd_ctrl.sv =====
module gbcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  gbcd_pkg::gbcd_status_t status,
    output gbcd_pkg::gbcd_cmd_t    cmd_out
);
    import gbcd_pkg::*;

    gbcd_state_t state_reg;
    gbcd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.clear_req ? ST_WIPE : ST_DONE;
            end
            ST_WIPE:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd_out         = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd_out.sweep = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd_out.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd_out.exec = 1'b1;
            end
            ST_WIPE:
            begin
                cmd_out.sweep = 1'b1;
            end
            ST_DONE:
            begin
                cmd_out.capture = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd_out = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/gbcd_dp.sv =====
module gbcd_dp #(
    parameter int DISPLAY_BYTES = gbcd_pkg::DISPLAY_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gbcd_pkg::gbcd_cmd_t    cmd_in,
    output gbcd_pkg::gbcd_status_t status,
    input  logic [1:0]             cmd,
    input  logic [10:0]            offset,
    input  logic [31:0]            write_value,
    input  logic [6:0]             peek_index,
    output logic [31:0]            read_data,
    output logic                   bad_offset,
    output logic [7:0]             display_char,
    output logic                   led_yellow,
    output logic                   led_green,
    output logic                   led_red
);
    import gbcd_pkg::*;

    localparam int         AW  = $clog2(DISPLAY_BYTES);
    localparam logic [8:0] DB9 = 9'(DISPLAY_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DISPLAY_BYTES - 1);

    // latched item
    logic [1:0]  cmd_reg;
    logic [10:0] offset_reg;
    logic [31:0] wval_reg;
    logic [6:0]  peek_reg;

    // bank registers
    logic [31:0] pe_reg [3];
    logic [31:0] oe_reg [3];
    logic [31:0] od_reg [3];
    logic [31:0] pe_next [3];
    logic [31:0] oe_next [3];
    logic [31:0] od_next [3];
    logic [7:0]  cursor_reg;
    logic [7:0]  cursor_next;

    // character store
    logic [7:0]    mem [DISPLAY_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic [AW-1:0] sweep_cnt_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // result registers
    logic [31:0] read_data_reg;
    logic        bad_reg;
    logic [7:0]  char_reg;
    logic        yellow_reg;
    logic        green_reg;
    logic        red_reg;

    // decode
    logic [1:0]  bank;
    logic [9:0]  rel;
    logic        wr_known;
    logic        rd_known;
    logic        is_display;
    logic [31:0] rd_value;
    logic        disp_act;
    logic        cmd_mode;
    logic        data_mode;
    logic [7:0]  cur_eff;
    logic [8:0]  peek9;
    logic        peek_ok;
    logic        wr_exec;
    logic [31:0] b_ctl;
    logic [31:0] c_ctl;

    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            cmd_reg    <= cmd;
            offset_reg <= offset;
            wval_reg   <= write_value;
            peek_reg   <= peek_index;
        end
    end

    always_comb
    begin
        if (offset_reg[10])
        begin
            bank = 2'd2;
        end
        else if (offset_reg[9])
        begin
            bank = 2'd1;
        end
        else
        begin
            bank = 2'd0;
        end
        rel = (bank == 2'd2) ? offset_reg[9:0] : {1'b0, offset_reg[8:0]};

        wr_known = (rel == REL_PE_SET) || (rel == REL_PE_CLR) || (rel == REL_OE_SET)
                || (rel == REL_OE_CLR) || (rel == REL_OD_SET) || (rel == REL_OD_CLR)
                || (rel == REL_NOP);
        is_display = (bank == 2'd0) && (rel == REL_DISPLAY);

        rd_known = 1'b1;
        rd_value = '0;
        case (rel)
            REL_PE_RD: rd_value = pe_reg[bank];
            REL_OE_RD: rd_value = oe_reg[bank];
            REL_OD_RD: rd_value = od_reg[bank];
            default:   rd_known = 1'b0;
        endcase
    end

    // display control from bank c
    assign disp_act  = ((pe_reg[2] & oe_reg[2] & DISPLAY_GATE) == DISPLAY_GATE)
                    && !od_reg[2][CS_POS];
    assign cmd_mode  = !od_reg[2][MODE_DATA] && !od_reg[2][MODE_HI];
    assign data_mode = od_reg[2][MODE_DATA];
    assign cur_eff   = ({1'b0, cursor_reg} >= DB9) ? 8'd0 : cursor_reg;
    assign wr_exec   = cmd_in.exec && (cmd_reg == CMD_WRITE) && !wr_known && is_display
                    && disp_act;

    assign status.clear_req  = wr_exec && cmd_mode && (wval_reg == 32'd1);
    assign status.sweep_last = cmd_in.sweep && (sweep_cnt_reg == LAST_ADDR);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pe_next[i] = pe_reg[i];
            oe_next[i] = oe_reg[i];
            od_next[i] = od_reg[i];
            if (cmd_in.exec && (cmd_reg == CMD_WRITE) && (bank == 2'(i)))
            begin
                case (rel)
                    REL_PE_SET: pe_next[i] = pe_reg[i] | wval_reg;
                    REL_PE_CLR: pe_next[i] = pe_reg[i] & ~wval_reg;
                    REL_OE_SET: oe_next[i] = oe_reg[i] | wval_reg;
                    REL_OE_CLR: oe_next[i] = oe_reg[i] & ~wval_reg;
                    REL_OD_SET: od_next[i] = od_reg[i] | wval_reg;
                    REL_OD_CLR: od_next[i] = od_reg[i] & ~wval_reg;
                    default:    od_next[i] = od_reg[i];
                endcase
            end
        end

        cursor_next = cursor_reg;
        mem_we      = 1'b0;
        mem_waddr   = sweep_cnt_reg;
        mem_wdata   = 8'd0;
        if (cmd_in.sweep)
        begin
            mem_we = 1'b1;
        end
        else if (wr_exec && cmd_mode)
        begin
            // bit length one, two, or at least eight
            if (wval_reg == 32'd1 || wval_reg[31:1] == 31'd1)
            begin
                cursor_next = 8'd0;
            end
            else if (wval_reg[31:7] != 25'd0)
            begin
                cursor_next = {1'b0, wval_reg[6:0]};
            end
        end
        else if (wr_exec && data_mode)
        begin
            mem_we      = 1'b1;
            mem_waddr   = cur_eff[AW-1:0];
            mem_wdata   = wval_reg[7:0];
            cursor_next = cur_eff + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pe_reg[i] <= '0;
                oe_reg[i] <= '0;
                od_reg[i] <= '0;
            end
            cursor_reg    <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                pe_reg[i] <= pe_next[i];
                oe_reg[i] <= oe_next[i];
                od_reg[i] <= od_next[i];
            end
            cursor_reg <= cursor_next;
            if (cmd_in.sweep)
            begin
                sweep_cnt_reg <= (sweep_cnt_reg == LAST_ADDR) ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    // peek read
    assign peek9     = {2'b00, peek_reg};
    assign peek_ok   = (cmd_reg == CMD_PEEK) && (peek9 < DB9);
    assign mem_re    = cmd_in.exec && peek_ok;
    assign mem_raddr = peek9[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign b_ctl = od_reg[1] & oe_reg[1] & pe_reg[1];
    assign c_ctl = od_reg[2] & oe_reg[2] & pe_reg[2];

    always_ff @(posedge clk)
    begin
        if (cmd_in.capture)
        begin
            read_data_reg <= (cmd_reg == CMD_READ) ? rd_value : 32'd0;
            case (cmd_reg)
                CMD_READ:  bad_reg <= !rd_known;
                CMD_WRITE: bad_reg <= !wr_known && !is_display;
                default:   bad_reg <= 1'b0;
            endcase
            char_reg   <= peek_ok ? mem_rdata_reg : 8'd0;
            yellow_reg <= b_ctl[YELLOW_POS];
            green_reg  <= c_ctl[GREEN_POS];
            red_reg    <= c_ctl[RED_POS];
        end
    end

    assign read_data    = read_data_reg;
    assign bad_offset   = bad_reg;
    assign display_char = char_reg;
    assign led_yellow   = yellow_reg;
    assign led_green    = green_reg;
    assign led_red      = red_reg;

endmodule

// ===== rtl/core/gpio_banks_with_char_display_core.sv =====
// channel   handshake               payload
// input     in_valid / in_ready     cmd, offset, write_value, peek_index
// output    out_valid / out_ready   read_data, bad_offset, display_char,
//                                   led_yellow, led_green, led_red
//
// one item at a time: accept, execute, capture, present, set by the
// controller's state sequence
// a display clear command adds a store wipe,
// one store entry written per cycle through the single write port
// after reset the same wipe runs; in_ready stays low
// a stalled result holds in the output registers and blocks the next item
module gpio_banks_with_char_display_core #(
    parameter int DISPLAY_BYTES = gbcd_pkg::DISPLAY_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [10:0] offset,
    input  logic [31:0] write_value,
    input  logic [6:0]  peek_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        bad_offset,
    output logic [7:0]  display_char,
    output logic        led_yellow,
    output logic        led_green,
    output logic        led_red
);
    import gbcd_pkg::*;

    // commands from the controller, status back from the datapath
    gbcd_cmd_t    dp_cmd;
    gbcd_status_t dp_status;

    // sequencer: init wipe, idle, execute, optional wipe, capture, present
    gbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd_out   (dp_cmd)
    );

    // bank registers, character store, cursor and result registers
    gbcd_dp #(
        .DISPLAY_BYTES (DISPLAY_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_in       (dp_cmd),
        .status       (dp_status),
        .cmd          (cmd),
        .offset       (offset),
        .write_value  (write_value),
        .peek_index   (peek_index),
        .read_data    (read_data),
        .bad_offset   (bad_offset),
        .display_char (display_char),
        .led_yellow   (led_yellow),
        .led_green    (led_green),
        .led_red      (led_red)
    );

endmodule

// ===== rtl/core/gbcd_checker.sv =====
module gbcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        bad_offset,
    input logic [7:0]  display_char
);

    // never takes an item while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // an accepted item cannot produce its result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid && !in_ready))
        else $error("result or new accept right after an accept");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_data)
            && $stable(display_char) && $stable(bad_offset)))
        else $error("stalled result changed");

    // a peek result never carries a bus error or bus data
    a_peek_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (display_char != 8'd0)) |-> (!bad_offset && (read_data == 32'd0)))
        else $error("peek result mixed with bus result");

    // an undecoded access returns no data
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_offset) |-> (read_data == 32'd0))
        else $error("bad offset with nonzero data");

endmodule

bind gpio_banks_with_char_display_core gbcd_checker u_gbcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .bad_offset   (bad_offset),
    .display_char (display_char)
);
